// ----- rtl/idq_pkg.sv -----
`default_nettype none
package idq_pkg;
	// Store depth must be a power of two: slots wrap by masking.
	localparam int DEPTH       = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int AW          = $clog2(DEPTH);
	localparam int CW          = $clog2(DEPTH + 1);
	localparam int ACT_W       = 4;
	localparam int POS_W       = 7;
	localparam int IN_W        = 32;
	localparam int AMT_W       = 32;
	localparam int ST_W        = 2;
	localparam int S_DATA_W    = 80;
	localparam int M_DATA_W    = 48;

	localparam logic [ACT_W-1:0] ACT_GET        = 4'd0;
	localparam logic [ACT_W-1:0] ACT_SET        = 4'd1;
	localparam logic [ACT_W-1:0] ACT_INS_BEFORE = 4'd2;
	localparam logic [ACT_W-1:0] ACT_INS_AFTER  = 4'd3;
	localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 4'd4;
	localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 4'd5;
	localparam logic [ACT_W-1:0] ACT_REMOVE     = 4'd6;
	localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 4'd7;
	localparam logic [ACT_W-1:0] ACT_POP_BACK   = 4'd8;
	localparam logic [ACT_W-1:0] ACT_ROTATE     = 4'd9;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

	// Physical slot of a logical index.
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
			input logic [CW-1:0] logical);
		return front + logical[AW-1:0];
	endfunction
endpackage
`default_nettype wire

// ----- rtl/indexed_ring_deque_unit.sv -----
`default_nettype none
// Channel | Dir | Handshake          | Payload (low bit up)
// s_*     | in  | s_tvalid/s_tready  | action[4] position[7] item_value[32] rotate_amount[32]
// m_*     | out | m_tvalid/m_tready  | result_value[32] current_length[7] status[2]
//
// One word at a time; the block takes a new word once it is back in idle after the
// last result word is loaded. Insert and remove shift one entry per step (up to
// DEPTH-1 entries); rotate first runs the remainder unit, then moves one position
// per step (up to length-1 positions). One element RAM access per cycle.
// Reset clears front slot, count and handshake state; RAM contents stay.
// A held result does not stop the next word from being accepted and worked;
// its result waits until the held one is taken.
module indexed_ring_deque_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// action, position, item_value, rotate_amount, zero pad
	input  wire logic [idq_pkg::S_DATA_W-1:0]  s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// result_value, current_length, status, zero pad
	output logic      [idq_pkg::M_DATA_W-1:0]  m_tdata
);
	localparam int AW = idq_pkg::AW;
	localparam int CW = idq_pkg::CW;
	localparam int VW = idq_pkg::VALUE_WIDTH;

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_DIV, S_RD, S_CAP, S_INS, S_INS_WR,
		S_RM, S_RM_WR, S_ROT, S_ROT_WR, S_DONE
	} state_t;

	state_t state_q;
	logic [idq_pkg::ACT_W-1:0] act_q;
	logic [idq_pkg::POS_W-1:0] pos_q;
	logic [VW-1:0]             val_q;
	logic [idq_pkg::AMT_W-1:0] amt_q;
	logic [AW-1:0]             front_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             at_q;
	logic [CW-1:0]             j_q;
	logic [CW-1:0]             lim_q;
	logic [VW-1:0]             res_q;
	logic [idq_pkg::ST_W-1:0]  st_q;

	// Resolve the signed position against the current length.
	logic [CW:0] p_ext, n_ext, p_sum;
	logic        in_rng, full, empty;
	logic [CW-1:0] at_res;
	assign p_ext  = {{(CW + 1 - idq_pkg::POS_W){pos_q[idq_pkg::POS_W-1]}}, pos_q};
	assign n_ext  = {1'b0, count_q};
	assign p_sum  = p_ext + n_ext;
	assign in_rng = ($signed(p_ext) < $signed(n_ext)) && !p_sum[CW];
	assign at_res = p_ext[CW] ? p_sum[CW-1:0] : p_ext[CW-1:0];
	assign full   = (count_q == CW'(idq_pkg::DEPTH));
	assign empty  = (count_q == '0);

	// Remainder unit for rotate.
	logic                      div_start, div_done;
	logic [idq_pkg::AMT_W-1:0] amt_mag;
	logic [CW-1:0]             div_rem, rot_k;
	assign amt_mag   = amt_q[idq_pkg::AMT_W-1] ? (~amt_q + 1'b1) : amt_q;
	assign div_start = (state_q == S_DEC) && (act_q == idq_pkg::ACT_ROTATE) && !empty;
	assign rot_k     = (amt_q[idq_pkg::AMT_W-1] && div_rem != '0) ? count_q - div_rem
	                                                             : div_rem;

	idq_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (amt_mag),
		.divisor  (count_q),
		.done     (div_done),
		.remainder(div_rem)
	);

	// Element RAM ports.
	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [VW-1:0] wdata, rdata;

	idq_ram #(.AW(AW), .DW(VW)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = '0;
		raddr = '0;
		wdata = rdata;
		unique case (state_q)
			S_DEC: begin
				// push front writes the slot ahead of the front
				if (act_q == idq_pkg::ACT_PUSH_FRONT && !full) begin
					we    = 1'b1;
					waddr = front_q - 1'b1;
					wdata = val_q;
				end
			end
			S_RD: begin
				re    = 1'b1;
				raddr = idq_pkg::slot_of(front_q, at_q);
			end
			S_CAP: begin
				if (act_q == idq_pkg::ACT_SET) begin
					we    = 1'b1;
					waddr = idq_pkg::slot_of(front_q, at_q);
					wdata = val_q;
				end
			end
			S_INS: begin
				if (j_q > lim_q) begin
					re    = 1'b1;
					raddr = idq_pkg::slot_of(front_q, j_q - 1'b1);
				end else begin
					we    = 1'b1;
					waddr = idq_pkg::slot_of(front_q, lim_q);
					wdata = val_q;
				end
			end
			S_INS_WR, S_RM_WR: begin
				we    = 1'b1;
				waddr = idq_pkg::slot_of(front_q, j_q);
			end
			S_RM: begin
				re    = (j_q + 1'b1) < count_q;
				raddr = idq_pkg::slot_of(front_q, j_q + 1'b1);
			end
			S_ROT: begin
				re    = (j_q != '0);
				raddr = idq_pkg::slot_of(front_q, count_q - 1'b1);
			end
			S_ROT_WR: begin
				we    = 1'b1;
				waddr = front_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			front_q  <= '0;
			count_q  <= '0;
			m_tvalid <= 1'b0;
		end else begin
			// S_DONE decides the output itself when it is ready to load
			if (m_tvalid && m_tready && state_q != S_DONE) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						act_q   <= s_tdata[3:0];
						pos_q   <= s_tdata[10:4];
						val_q   <= s_tdata[42:11];
						amt_q   <= s_tdata[74:43];
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					res_q   <= '0;
					st_q    <= idq_pkg::ST_OK;
					state_q <= S_DONE;
					unique case (act_q)
						idq_pkg::ACT_GET, idq_pkg::ACT_SET: begin
							if (!in_rng) begin
								st_q <= idq_pkg::ST_RANGE;
							end else begin
								at_q    <= at_res;
								state_q <= S_RD;
							end
						end
						idq_pkg::ACT_INS_BEFORE, idq_pkg::ACT_INS_AFTER: begin
							if (!in_rng) begin
								st_q <= idq_pkg::ST_RANGE;
							end else if (full) begin
								st_q <= idq_pkg::ST_FULL;
							end else begin
								res_q   <= val_q;
								j_q     <= count_q;
								lim_q   <= (act_q == idq_pkg::ACT_INS_AFTER) ? at_res + 1'b1
								                                              : at_res;
								state_q <= S_INS;
							end
						end
						idq_pkg::ACT_PUSH_FRONT: begin
							if (full) begin
								st_q <= idq_pkg::ST_FULL;
							end else begin
								res_q   <= val_q;
								front_q <= front_q - 1'b1;
								count_q <= count_q + 1'b1;
							end
						end
						idq_pkg::ACT_PUSH_BACK: begin
							if (full) begin
								st_q <= idq_pkg::ST_FULL;
							end else begin
								res_q   <= val_q;
								j_q     <= count_q;
								lim_q   <= count_q;
								state_q <= S_INS;
							end
						end
						idq_pkg::ACT_REMOVE: begin
							if (empty) begin
								st_q <= idq_pkg::ST_EMPTY;
							end else if (!in_rng) begin
								st_q <= idq_pkg::ST_RANGE;
							end else begin
								at_q    <= at_res;
								state_q <= S_RD;
							end
						end
						idq_pkg::ACT_POP_FRONT, idq_pkg::ACT_POP_BACK: begin
							if (empty) begin
								st_q <= idq_pkg::ST_EMPTY;
							end else begin
								at_q    <= (act_q == idq_pkg::ACT_POP_FRONT) ? '0
								                                              : count_q - 1'b1;
								state_q <= S_RD;
							end
						end
						idq_pkg::ACT_ROTATE: begin
							if (empty) begin
								st_q <= idq_pkg::ST_EMPTY;
							end else begin
								state_q <= S_DIV;
							end
						end
						default: begin
						end
					endcase
				end
				S_RD: begin
					state_q <= S_CAP;
				end
				S_CAP: begin
					res_q   <= rdata;
					state_q <= S_DONE;
					if (act_q == idq_pkg::ACT_POP_FRONT) begin
						front_q <= front_q + 1'b1;
						count_q <= count_q - 1'b1;
					end else if (act_q == idq_pkg::ACT_REMOVE ||
					             act_q == idq_pkg::ACT_POP_BACK) begin
						j_q     <= at_q;
						state_q <= S_RM;
					end
				end
				S_INS: begin
					// shift the tail up one slot, then drop the new word in
					if (j_q > lim_q) begin
						state_q <= S_INS_WR;
					end else begin
						count_q <= count_q + 1'b1;
						state_q <= S_DONE;
					end
				end
				S_INS_WR: begin
					j_q     <= j_q - 1'b1;
					state_q <= S_INS;
				end
				S_RM: begin
					// close the gap by moving later words down
					if ((j_q + 1'b1) < count_q) begin
						state_q <= S_RM_WR;
					end else begin
						count_q <= count_q - 1'b1;
						state_q <= S_DONE;
					end
				end
				S_RM_WR: begin
					j_q     <= j_q + 1'b1;
					state_q <= S_RM;
				end
				S_DIV: begin
					if (div_done) begin
						j_q     <= rot_k;
						state_q <= S_ROT;
					end
				end
				S_ROT: begin
					// each step moves the last word in front of the first
					state_q <= (j_q != '0) ? S_ROT_WR : S_DONE;
				end
				S_ROT_WR: begin
					front_q <= front_q - 1'b1;
					j_q     <= j_q - 1'b1;
					state_q <= S_ROT;
				end
				S_DONE: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {7'b0, st_q, count_q, res_q};
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/idq_ram.sv -----
`default_nettype none
module idq_ram #(
	parameter int AW = 6,
	parameter int DW = 32
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- rtl/idq_mod.sv -----
`default_nettype none
// Restoring remainder, one dividend bit per cycle.
module idq_mod (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [idq_pkg::AMT_W-1:0]  dividend,
	input  wire logic [idq_pkg::CW-1:0]     divisor,
	output logic                            done,
	output logic      [idq_pkg::CW-1:0]     remainder
);
	localparam int CNT_W = $clog2(idq_pkg::AMT_W);

	logic                      busy_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [idq_pkg::AMT_W-1:0] sh_q;
	logic [idq_pkg::CW-1:0]    dv_q;
	logic [idq_pkg::CW:0]      rem_q;
	logic [idq_pkg::CW:0]      trial;

	assign trial     = {rem_q[idq_pkg::CW-1:0], sh_q[idq_pkg::AMT_W-1]};
	assign remainder = rem_q[idq_pkg::CW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				sh_q   <= dividend;
				dv_q   <= divisor;
				rem_q  <= '0;
			end else if (busy_q) begin
				sh_q <= {sh_q[idq_pkg::AMT_W-2:0], 1'b0};
				if (trial >= {1'b0, dv_q}) begin
					rem_q <= trial - {1'b0, dv_q};
				end else begin
					rem_q <= trial;
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(idq_pkg::AMT_W - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/idq_chk.sv -----
`default_nettype none
module idq_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic [idq_pkg::S_DATA_W-1:0]  s_tdata,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [idq_pkg::M_DATA_W-1:0]  m_tdata
);
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("input word changed while waiting");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[38:32] <= 7'(idq_pkg::DEPTH))
		else $error("length beyond depth");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[40:39] == idq_pkg::ST_FULL
		|-> m_tdata[38:32] == 7'(idq_pkg::DEPTH))
		else $error("full status on a store that is not full");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[40:39] == idq_pkg::ST_EMPTY
		|-> m_tdata[38:32] == 7'd0 && m_tdata[31:0] == 32'd0)
		else $error("empty status with data or nonzero length");
endmodule

bind indexed_ring_deque_unit idq_chk u_idq_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
`default_nettype wire
